FILE: design/svf_pkg.sv
// Shared types, register indexes and saturation helpers for the state variable filter.
package svf_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned ACC_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_ONE        = 3'd0,
    CFG_COEF_TWO        = 3'd1,
    CFG_COEF_THREE      = 3'd2,
    CFG_DAMPING         = 3'd3,
    CFG_LOWPASS_GAIN    = 3'd4,
    CFG_BANDPASS_GAIN   = 3'd5,
    CFG_HIGHPASS_GAIN   = 3'd6,
    CFG_BANDREJECT_GAIN = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_G1_V3,
    OP_G2_BAND,
    OP_G3_V3,
    OP_G4_BAND,
    OP_RQ_NB,
    OP_LPG_NL,
    OP_BPG_NB,
    OP_HPG_HP,
    OP_BRG_BR
  } op_t;

  localparam logic signed [ACC_W-1:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -40'sd2147483648;
  localparam logic signed [ACC_W-1:0] S24_MAX = 40'sd8388607;
  localparam logic signed [ACC_W-1:0] S24_MIN = -40'sd8388608;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < S32_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [23:0] r;
    if (v > S24_MAX) begin
      r = 24'sh7f_ffff;
    end else if (v < S24_MIN) begin
      r = 24'sh80_0000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

FILE: design/state_variable_filter_unit.sv
// Two-pole trapezoidal state variable filter with one shared multiplier.
//
// Input channel in_valid/in_stall/in_sample_in carries one Q1.23 sample per item.
// Result channel out_valid/out_stall/out_sample_out carries the mixed, saturated
// Q1.23 output, one result per input item, in order.
// Configuration: cfg_we, cfg_idx, cfg_wdata write the eight coefficient and gain
// registers; write only while no item is in flight.
// Each item runs nine products through one 33x32 signed multiplier; each product
// is multiplied, then rounded and accumulated. A new item is taken the cycle after
// the result is accepted, so no new item is taken before the last result has left.
// in_stall is high from the accept edge until the result leaves the output
// register. While out_stall is high the result is held and no item is taken.
// Reset (synchronous, rst_n low) clears the filter states and previous input,
// loads damping and low-pass gain with 1.0 and the other registers with 0.
module state_variable_filter_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [23:0]                   in_sample_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [23:0]                   out_sample_out,
  input  logic                                 cfg_we,
  input  logic [svf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  logic [svf_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int unsigned AW = svf_pkg::ACC_W;

  logic [30:0]        coef_one_r, coef_two_r, coef_three_r, damping_r;
  logic signed [31:0] lp_gain_r, bp_gain_r, hp_gain_r, br_gain_r;

  logic signed [23:0] prev_r, x_r;
  logic signed [31:0] band_r, low_r;
  logic signed [31:0] v3_r, nb_r, nl_r, br_r, hp_r;
  logic signed [AW-1:0] acc_r;
  logic signed [64:0] prod_r;
  logic signed [23:0] out_r;

  svf_pkg::state_t state_r, state_nxt;
  svf_pkg::op_t    op_r, op_nxt;

  logic               in_acc, out_acc;
  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic               sub_sel;
  logic signed [65:0] prod_rnd;
  logic signed [AW-1:0] term, acc_sum;
  logic signed [AW-1:0] v3_sum;
  logic signed [31:0] sum_sat;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state_r != svf_pkg::ST_IDLE);
  assign out_valid = (state_r == svf_pkg::ST_OUT);
  assign out_sample_out = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_one_r   <= '0;
      coef_two_r   <= '0;
      coef_three_r <= '0;
      damping_r    <= 31'h1000_0000;
      lp_gain_r    <= 32'sh1000_0000;
      bp_gain_r    <= '0;
      hp_gain_r    <= '0;
      br_gain_r    <= '0;
    end else if (cfg_we) begin
      case (svf_pkg::cfg_idx_t'(cfg_idx))
        svf_pkg::CFG_COEF_ONE:        coef_one_r   <= cfg_wdata[30:0];
        svf_pkg::CFG_COEF_TWO:        coef_two_r   <= cfg_wdata[30:0];
        svf_pkg::CFG_COEF_THREE:      coef_three_r <= cfg_wdata[30:0];
        svf_pkg::CFG_DAMPING:         damping_r    <= cfg_wdata[30:0];
        svf_pkg::CFG_LOWPASS_GAIN:    lp_gain_r    <= $signed(cfg_wdata);
        svf_pkg::CFG_BANDPASS_GAIN:   bp_gain_r    <= $signed(cfg_wdata);
        svf_pkg::CFG_HIGHPASS_GAIN:   hp_gain_r    <= $signed(cfg_wdata);
        svf_pkg::CFG_BANDREJECT_GAIN: br_gain_r    <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sub_sel = 1'b0;
    case (op_r)
      svf_pkg::OP_G1_V3: begin
        mul_a = $signed({2'b00, coef_one_r});
        mul_b = v3_r;
      end
      svf_pkg::OP_G2_BAND: begin
        mul_a   = $signed({2'b00, coef_two_r});
        mul_b   = band_r;
        sub_sel = 1'b1;
      end
      svf_pkg::OP_G3_V3: begin
        mul_a = $signed({2'b00, coef_three_r});
        mul_b = v3_r;
      end
      svf_pkg::OP_G4_BAND: begin
        mul_a = $signed({1'b0, coef_one_r, 1'b0});
        mul_b = band_r;
      end
      svf_pkg::OP_RQ_NB: begin
        mul_a   = $signed({2'b00, damping_r});
        mul_b   = nb_r;
        sub_sel = 1'b1;
      end
      svf_pkg::OP_LPG_NL: begin
        mul_a = $signed({lp_gain_r[31], lp_gain_r});
        mul_b = nl_r;
      end
      svf_pkg::OP_BPG_NB: begin
        mul_a = $signed({bp_gain_r[31], bp_gain_r});
        mul_b = nb_r;
      end
      svf_pkg::OP_HPG_HP: begin
        mul_a = $signed({hp_gain_r[31], hp_gain_r});
        mul_b = hp_r;
      end
      svf_pkg::OP_BRG_BR: begin
        mul_a = $signed({br_gain_r[31], br_gain_r});
        mul_b = br_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    prod_rnd = $signed({prod_r[64], prod_r}) + 66'sd134217728;
    term     = $signed({{2{prod_rnd[65]}}, prod_rnd[65:28]});
    acc_sum  = sub_sel ? (acc_r - term) : (acc_r + term);
    sum_sat  = svf_pkg::sat32(acc_sum);
    v3_sum   = $signed({{16{in_sample_in[23]}}, in_sample_in})
             + $signed({{16{prev_r[23]}}, prev_r})
             - $signed({{7{low_r[31]}}, low_r, 1'b0});
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      svf_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = svf_pkg::ST_MUL;
          op_nxt    = svf_pkg::OP_G1_V3;
        end
      end
      svf_pkg::ST_MUL: state_nxt = svf_pkg::ST_ACC;
      svf_pkg::ST_ACC: begin
        if (op_r == svf_pkg::OP_BRG_BR) begin
          state_nxt = svf_pkg::ST_OUT;
        end else begin
          state_nxt = svf_pkg::ST_MUL;
          op_nxt    = svf_pkg::op_t'(op_r + 4'd1);
        end
      end
      svf_pkg::ST_OUT: begin
        if (out_acc) begin
          state_nxt = svf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = svf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= svf_pkg::ST_IDLE;
      op_r    <= svf_pkg::OP_G1_V3;
      prev_r  <= '0;
      band_r  <= '0;
      low_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      if (state_r == svf_pkg::ST_ACC && op_r == svf_pkg::OP_BRG_BR) begin
        prev_r <= x_r;
        band_r <= nb_r;
        low_r  <= nl_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r   <= in_sample_in;
      v3_r  <= svf_pkg::sat32(v3_sum);
      acc_r <= $signed({{8{band_r[31]}}, band_r});
    end
    if (state_r == svf_pkg::ST_MUL) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == svf_pkg::ST_ACC) begin
      case (op_r)
        svf_pkg::OP_G2_BAND: begin
          nb_r  <= sum_sat;
          acc_r <= $signed({{8{low_r[31]}}, low_r});
        end
        svf_pkg::OP_G4_BAND: begin
          nl_r  <= sum_sat;
          acc_r <= $signed({{16{x_r[23]}}, x_r});
        end
        svf_pkg::OP_RQ_NB: begin
          br_r  <= sum_sat;
          acc_r <= '0;
        end
        svf_pkg::OP_LPG_NL: begin
          hp_r  <= svf_pkg::sat32($signed({{8{br_r[31]}}, br_r})
                                - $signed({{8{nl_r[31]}}, nl_r}));
          acc_r <= acc_sum;
        end
        svf_pkg::OP_BRG_BR: out_r <= svf_pkg::sat24(acc_sum);
        default: acc_r <= acc_sum;
      endcase
    end
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> !out_valid)
    else $error("result delivered twice");

  a_start_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == svf_pkg::ST_MUL) && (op_r == svf_pkg::OP_G1_V3))
    else $error("sequencer did not start at the first product");

  a_state_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == svf_pkg::ST_OUT) |-> (band_r == nb_r) && (low_r == nl_r))
    else $error("filter state not committed with the result");

endmodule
